>>> src/huffman_archive_decoder_core_assert.svh
// Assertion macros used by the checker file hap_checker.sv.
`ifndef HUFFMAN_ARCHIVE_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_ARCHIVE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HAP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hap assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HAP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hap assertion failed");

`endif

>>> src/hap_pkg.sv
// ----------------------------------------------------------------------------
// hap_pkg
// Shared widths, status codes and control structs of the archive decoder.
// ----------------------------------------------------------------------------
package hap_pkg;

    localparam int SYM_W         = 8;
    localparam int LEN_W         = 6;
    localparam int MAX_CODE_BITS = 32;
    localparam int TBL_DEPTH     = 256;
    localparam int ADDR_W        = 8;
    localparam int CNT_W         = 9;
    localparam int TBL_W         = SYM_W + LEN_W + MAX_CODE_BITS;

    localparam logic [1:0] ST_SYMBOL   = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_HEADER   = 2'd3;

    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
        logic [SYM_W-1:0]         sym;
        logic [LEN_W-1:0]         len;
        logic [MAX_CODE_BITS-1:0] code;
    } t_tbl_wr;

    typedef struct packed {
        logic                     start;
        logic                     clear;
        logic [MAX_CODE_BITS-1:0] acc;
        logic [LEN_W-1:0]         len;
        logic [CNT_W-1:0]         total;
    } t_match_req;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [SYM_W-1:0] sym;
    } t_match_rsp;

endpackage

>>> src/hap_ram.sv
// ----------------------------------------------------------------------------
// hap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/hap_match.sv
// ----------------------------------------------------------------------------
// hap_match
// Code table storage and search: scans entries from the newest down.
// ----------------------------------------------------------------------------
module hap_match (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hap_pkg::t_tbl_wr    i_wr,
    input  hap_pkg::t_match_req i_req,
    output hap_pkg::t_match_rsp o_rsp
);

    import hap_pkg::*;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_WAIT = 2'd1;
    localparam logic [1:0] M_CMP  = 2'd2;

    logic [1:0]               r_st, n_st;
    logic [ADDR_W-1:0]        r_idx, n_idx;
    logic [MAX_CODE_BITS:1]   r_mask, n_mask;
    logic                     r_done, n_done;
    logic                     r_hit, n_hit;
    logic [SYM_W-1:0]         r_sym, n_sym;
    logic [TBL_W-1:0]         w_rdata;
    logic [SYM_W-1:0]         w_esym;
    logic [LEN_W-1:0]         w_elen;
    logic [MAX_CODE_BITS-1:0] w_ecode;
    logic                     w_known;
    logic                     w_eq;

    hap_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata ({i_wr.sym, i_wr.len, i_wr.code}),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign {w_esym, w_elen, w_ecode} = w_rdata;
    assign w_known = (i_req.len != '0) && (i_req.len <= LEN_W'(MAX_CODE_BITS))
                     && r_mask[i_req.len] && (i_req.total != '0);
    assign w_eq = (w_elen == i_req.len) && (w_elen != '0) && (w_ecode == i_req.acc);

    always_comb begin
        n_st   = r_st;
        n_idx  = r_idx;
        n_mask = r_mask;
        n_done = 1'b0;
        n_hit  = r_hit;
        n_sym  = r_sym;
        if (i_wr.en && (i_wr.len != '0)) begin
            n_mask[i_wr.len] = 1'b1;
        end
        if (i_req.clear) begin
            n_mask = '0;
        end
        case (r_st)
            M_IDLE: begin
                if (i_req.start) begin
                    if (w_known) begin
                        n_idx = ADDR_W'(i_req.total - CNT_W'(1));
                        n_st  = M_WAIT;
                    end else begin
                        n_done = 1'b1;
                        n_hit  = 1'b0;
                    end
                end
            end
            M_WAIT: n_st = M_CMP;
            M_CMP: begin
                if (w_eq) begin
                    n_done = 1'b1;
                    n_hit  = 1'b1;
                    n_sym  = w_esym;
                    n_st   = M_IDLE;
                end else if (r_idx == '0) begin
                    n_done = 1'b1;
                    n_hit  = 1'b0;
                    n_st   = M_IDLE;
                end else begin
                    n_idx = r_idx - ADDR_W'(1);
                    n_st  = M_WAIT;
                end
            end
            default: n_st = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= M_IDLE;
            r_mask <= '0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_mask <= n_mask;
            r_done <= n_done;
            r_hit  <= n_hit;
        end
        r_idx <= n_idx;
        r_sym <= n_sym;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hit  = r_hit;
    assign o_rsp.sym  = r_sym;

endmodule

>>> src/huffman_archive_decoder_core.sv
// ----------------------------------------------------------------------------
// huffman_archive_decoder_core
// Byte-stream archive decoder: header parse, code table, bit-serial decode.
// ----------------------------------------------------------------------------
// Header bytes take one request each. A data byte is shifted out one bit at
// a time, MSB first; every bit then searches the code table held in a RAM
// with one write and one read port, newest entry first, through a wait and a
// compare state per entry, and only when some stored code has the current
// length. Results leave through an output register and one pending slot; the
// next request is taken only once the last result of the current one has
// moved into the output register, so a receiver that holds off stalls the
// input. The last result of each request carries run_end.
module huffman_archive_decoder_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_archive_byte,
    input  logic                      i_final_byte,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [hap_pkg::SYM_W-1:0] o_symbol,
    output logic [1:0]                o_status,
    output logic                      o_run_end
);

    import hap_pkg::*;

    // Header parse phases
    localparam logic [2:0] PH_COUNT  = 3'd0;
    localparam logic [2:0] PH_SYMBOL = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_CODE   = 3'd3;
    localparam logic [2:0] PH_REM    = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_ERROR  = 3'd6;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BIT    = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_MATCH  = 3'd3;
    localparam logic [2:0] S_POST   = 3'd4;
    localparam logic [2:0] S_TAIL   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]               r_state, n_state;
    logic [2:0]               r_ret, n_ret;
    logic [2:0]               r_phase, n_phase;
    logic [2:0]               r_hidx, n_hidx;
    logic [CNT_W-1:0]         r_total, n_total;
    logic                     r_big, n_big;
    logic [CNT_W-1:0]         r_eidx, n_eidx;
    logic [SYM_W-1:0]         r_psym, n_psym;
    logic [LEN_W-1:0]         r_plen, n_plen;
    logic [LEN_W-1:0]         r_pcnt, n_pcnt;
    logic                     r_pbad, n_pbad;
    logic [MAX_CODE_BITS-1:0] r_pcode, n_pcode;
    logic [2:0]               r_tail, n_tail;
    logic [MAX_CODE_BITS-1:0] r_acc, n_acc;
    logic [LEN_W-1:0]         r_alen, n_alen;
    logic [7:0]               r_sr, n_sr;
    logic [3:0]               r_nb, n_nb;
    logic                     r_fin, n_fin;
    logic                     r_err, n_err;
    logic                     r_trunc, n_trunc;
    logic                     r_pend_v, n_pend_v;
    logic [SYM_W-1:0]         r_pend_sym, n_pend_sym;
    logic [1:0]               r_pend_st, n_pend_st;
    logic [SYM_W-1:0]         r_post_sym, n_post_sym;
    logic [1:0]               r_post_st, n_post_st;
    logic                     r_out_v, n_out_v;
    logic [SYM_W-1:0]         r_o_sym, n_o_sym;
    logic [1:0]               r_o_st, n_o_st;
    logic                     r_o_end, n_o_end;

    t_tbl_wr    w_wr;
    t_match_req w_req;
    t_match_rsp w_rsp;
    logic       w_accept;
    logic       w_out_free;
    logic       w_clear;
    logic [3:0] w_nb;

    hap_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_v || i_ready;
    assign w_nb       = (i_final_byte && (r_tail != '0)) ? {1'b0, r_tail} : 4'd8;

    assign w_req.start = (r_state == S_SEARCH);
    assign w_req.clear = w_clear;
    assign w_req.acc   = r_acc;
    assign w_req.len   = r_alen;
    assign w_req.total = r_total;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_phase    = r_phase;
        n_hidx     = r_hidx;
        n_total    = r_total;
        n_big      = r_big;
        n_eidx     = r_eidx;
        n_psym     = r_psym;
        n_plen     = r_plen;
        n_pcnt     = r_pcnt;
        n_pbad     = r_pbad;
        n_pcode    = r_pcode;
        n_tail     = r_tail;
        n_acc      = r_acc;
        n_alen     = r_alen;
        n_sr       = r_sr;
        n_nb       = r_nb;
        n_fin      = r_fin;
        n_err      = r_err;
        n_trunc    = r_trunc;
        n_pend_v   = r_pend_v;
        n_pend_sym = r_pend_sym;
        n_pend_st  = r_pend_st;
        n_post_sym = r_post_sym;
        n_post_st  = r_post_st;
        n_out_v    = r_out_v && !i_ready;
        n_o_sym    = r_o_sym;
        n_o_st     = r_o_st;
        n_o_end    = r_o_end;
        w_clear    = 1'b0;
        w_wr.en    = 1'b0;
        w_wr.addr  = r_eidx[ADDR_W-1:0];
        w_wr.sym   = r_psym;
        w_wr.len   = r_plen;
        w_wr.code  = r_pcode;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_err = 1'b0;
                    case (r_phase)
                        PH_COUNT: begin
                            // Little-endian count; anything above bit 8 marks too big
                            case (r_hidx)
                                3'd0: n_total[7:0] = i_archive_byte;
                                3'd1: begin
                                    n_total[8] = i_archive_byte[0];
                                    n_big      = r_big || (i_archive_byte[7:1] != '0);
                                end
                                default: n_big = r_big || (i_archive_byte != '0);
                            endcase
                            n_hidx = r_hidx + 3'd1;
                            if (r_hidx == 3'd7) begin
                                if (n_big || (n_total > CNT_W'(TBL_DEPTH))) begin
                                    n_phase = PH_ERROR;
                                    n_err   = 1'b1;
                                end else begin
                                    n_eidx  = '0;
                                    n_phase = (n_total == '0) ? PH_REM : PH_SYMBOL;
                                end
                            end
                        end
                        PH_SYMBOL: begin
                            n_psym  = i_archive_byte;
                            n_phase = PH_LENGTH;
                        end
                        PH_LENGTH: begin
                            if (i_archive_byte > 8'(MAX_CODE_BITS)) begin
                                n_phase = PH_ERROR;
                                n_err   = 1'b1;
                            end else begin
                                n_plen  = LEN_W'(i_archive_byte);
                                n_pcnt  = '0;
                                n_pcode = '0;
                                n_pbad  = 1'b0;
                                if (i_archive_byte == '0) begin
                                    // Empty code: store an entry that never matches
                                    w_wr.en   = !r_eidx[CNT_W-1];
                                    w_wr.len  = '0;
                                    w_wr.code = '0;
                                    n_eidx    = r_eidx + CNT_W'(1);
                                    n_phase   = (n_eidx >= r_total) ? PH_REM : PH_SYMBOL;
                                end else begin
                                    n_phase = PH_CODE;
                                end
                            end
                        end
                        PH_CODE: begin
                            if ((i_archive_byte == 8'h30) || (i_archive_byte == 8'h31)) begin
                                n_pcode = {r_pcode[MAX_CODE_BITS-2:0], i_archive_byte[0]};
                            end else begin
                                n_pbad = 1'b1;
                            end
                            n_pcnt = r_pcnt + LEN_W'(1);
                            if (n_pcnt >= r_plen) begin
                                // A bad code character stores length zero
                                w_wr.en   = !r_eidx[CNT_W-1];
                                w_wr.len  = n_pbad ? '0 : r_plen;
                                w_wr.code = n_pcode;
                                n_eidx    = r_eidx + CNT_W'(1);
                                n_phase   = (n_eidx >= r_total) ? PH_REM : PH_SYMBOL;
                            end
                        end
                        PH_REM: begin
                            n_tail  = i_archive_byte[2:0];
                            n_phase = PH_DATA;
                        end
                        default: ;
                    endcase
                    n_fin   = i_final_byte;
                    n_trunc = i_final_byte && (n_phase != PH_DATA) && (n_phase != PH_ERROR);
                    if (r_phase == PH_DATA) begin
                        // Align the used bits to the top of the shifter
                        n_nb    = w_nb;
                        n_sr    = i_archive_byte << 3'(4'd8 - w_nb);
                        n_state = S_BIT;
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_BIT: begin
                if (r_nb == '0) begin
                    n_state = S_TAIL;
                end else begin
                    n_acc   = {r_acc[MAX_CODE_BITS-2:0], r_sr[7]};
                    n_alen  = r_alen + LEN_W'(1);
                    n_sr    = {r_sr[6:0], 1'b0};
                    n_nb    = r_nb - 4'd1;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: n_state = S_MATCH;
            S_MATCH: begin
                if (w_rsp.done) begin
                    if (w_rsp.hit) begin
                        n_acc      = '0;
                        n_alen     = '0;
                        n_post_sym = w_rsp.sym;
                        n_post_st  = ST_SYMBOL;
                        n_ret      = S_BIT;
                        n_state    = S_POST;
                    end else if (r_alen >= LEN_W'(MAX_CODE_BITS)) begin
                        n_acc      = '0;
                        n_alen     = '0;
                        n_post_sym = '0;
                        n_post_st  = ST_OVERFLOW;
                        n_ret      = S_BIT;
                        n_state    = S_POST;
                    end else begin
                        n_state = S_BIT;
                    end
                end
            end
            S_POST: begin
                // Hold the newest result back so run_end can be set later
                if (!r_pend_v) begin
                    n_pend_v   = 1'b1;
                    n_pend_sym = r_post_sym;
                    n_pend_st  = r_post_st;
                    n_state    = r_ret;
                end else if (w_out_free) begin
                    n_out_v    = 1'b1;
                    n_o_sym    = r_pend_sym;
                    n_o_st     = r_pend_st;
                    n_o_end    = 1'b0;
                    n_pend_sym = r_post_sym;
                    n_pend_st  = r_post_st;
                    n_state    = r_ret;
                end
            end
            S_TAIL: begin
                n_post_sym = '0;
                n_ret      = S_TAIL;
                if (r_err) begin
                    n_err     = 1'b0;
                    n_post_st = ST_HEADER;
                    n_state   = S_POST;
                end else if (r_trunc) begin
                    n_trunc   = 1'b0;
                    n_post_st = ST_HEADER;
                    n_state   = S_POST;
                end else if (r_fin) begin
                    // End of archive: drop leftover bits, reset for the next one
                    n_fin     = 1'b0;
                    n_post_st = ST_END;
                    n_phase   = PH_COUNT;
                    n_hidx    = '0;
                    n_total   = '0;
                    n_big     = 1'b0;
                    n_eidx    = '0;
                    n_tail    = '0;
                    n_acc     = '0;
                    n_alen    = '0;
                    w_clear   = 1'b1;
                    n_state   = S_POST;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_v  = 1'b1;
                    n_o_sym  = r_pend_sym;
                    n_o_st   = r_pend_st;
                    n_o_end  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_phase  <= PH_COUNT;
            r_hidx   <= '0;
            r_total  <= '0;
            r_big    <= 1'b0;
            r_eidx   <= '0;
            r_tail   <= '0;
            r_acc    <= '0;
            r_alen   <= '0;
            r_nb     <= '0;
            r_fin    <= 1'b0;
            r_err    <= 1'b0;
            r_trunc  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_phase  <= n_phase;
            r_hidx   <= n_hidx;
            r_total  <= n_total;
            r_big    <= n_big;
            r_eidx   <= n_eidx;
            r_tail   <= n_tail;
            r_acc    <= n_acc;
            r_alen   <= n_alen;
            r_nb     <= n_nb;
            r_fin    <= n_fin;
            r_err    <= n_err;
            r_trunc  <= n_trunc;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_psym     <= n_psym;
        r_plen     <= n_plen;
        r_pcnt     <= n_pcnt;
        r_pbad     <= n_pbad;
        r_pcode    <= n_pcode;
        r_sr       <= n_sr;
        r_pend_sym <= n_pend_sym;
        r_pend_st  <= n_pend_st;
        r_post_sym <= n_post_sym;
        r_post_st  <= n_post_st;
        r_o_sym    <= n_o_sym;
        r_o_st     <= n_o_st;
        r_o_end    <= n_o_end;
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_v;
    assign o_symbol  = r_o_sym;
    assign o_status  = r_o_st;
    assign o_run_end = r_o_end;

endmodule

>>> src/hap_checker.sv
// ----------------------------------------------------------------------------
// hap_checker
// Port-level checks of the archive decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "huffman_archive_decoder_core_assert.svh"

module hap_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [hap_pkg::SYM_W-1:0] o_symbol,
    input logic [1:0]                o_status,
    input logic                      o_run_end
);

    import hap_pkg::*;

    `HAP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_symbol) && $stable(o_status) && $stable(o_run_end))
    `HAP_ASSERT_NOW(a_sym_zero, i_clk, i_rst_n, o_valid && (o_status != ST_SYMBOL), o_symbol == '0)
    `HAP_ASSERT_NOW(a_end_last, i_clk, i_rst_n, o_valid && (o_status == ST_END), o_run_end)
    `HAP_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

bind huffman_archive_decoder_core hap_checker u_hap_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_symbol  (o_symbol),
    .o_status  (o_status),
    .o_run_end (o_run_end)
);
